// ===== rtl/core/bqc_pkg.sv =====
// Shared types and constants for the biquad cascade filter.
package bqc_pkg;

  // Coefficient format: signed Q2.14 fields packed in the config registers
  localparam int COEF_W     = 16;
  localparam int COEF_SETS  = 2;
  localparam int SEC_W      = 1;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SECTIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEC0_NUM        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEC0_DEN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC1_NUM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEC1_DEN        = 3'd4;

  // MAC sequence: one product per step, then one drain step
  localparam logic [STEP_W-1:0] STEP_B0    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_B1    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_B2    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_A1    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_A2    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_FIN,
    S_PUSH
  } bqc_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              start;      // load input sample, clear clip flag
    logic              mul_en;     // register one product
    logic              acc_en;     // fold registered product into accumulator
    logic              acc_first;  // first product of a section
    logic [STEP_W-1:0] step;       // which term to multiply
    logic [SEC_W-1:0]  sec;        // section being computed
    logic              fin;        // round, saturate, update section state
    logic              load_out;   // move result into output register
  } bqc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_sec;
    logic out_free;
  } bqc_status_t;

endpackage

// ===== rtl/core/bqc_ctrl.sv =====
// Sequencer for the biquad cascade: walks sections and MAC steps.
module bqc_ctrl
  import bqc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  bqc_status_t status,
  output bqc_cmd_t    cmd
);

  bqc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sec_r   <= sec_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sec_nxt   = sec_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MAC;
          step_nxt  = STEP_B0;
          sec_nxt   = '0;
        end
      end
      S_MAC: begin
        if (step_r == STEP_DRAIN) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FIN: begin
        if (status.last_sec) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_MAC;
          step_nxt  = STEP_B0;
          sec_nxt   = sec_r + SEC_W'(1);
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.sec       = sec_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      S_MAC: begin
        cmd.mul_en    = (step_r != STEP_DRAIN);
        cmd.acc_en    = (step_r != STEP_B0);
        cmd.acc_first = (step_r == STEP_B1);
      end
      S_FIN: begin
        cmd.fin = 1'b1;
      end
      S_PUSH: begin
        cmd.load_out = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/bqc_dp.sv =====
// Datapath: config registers, section state, shared multiplier and accumulator.
module bqc_dp
  import bqc_pkg::*;
#(
  parameter int SECTIONS       = 2,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [SAMPLE_WIDTH-1:0] sample_in,
  input  bqc_cmd_t                cmd,
  output bqc_status_t             status,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [SAMPLE_WIDTH-1:0] sample_out,
  output logic                    saturated
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int PROD_W = COEF_W + SW;
  localparam int ACC_W  = SW + 19;
  localparam int MAXN   = (SECTIONS < COEF_SETS) ? SECTIONS : COEF_SETS;
  localparam logic [1:0] MAXN_V = 2'(MAXN);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  logic [1:0]                active_r;
  logic [3*COEF_W-1:0]       num_r [COEF_SETS];
  logic [2*COEF_W-1:0]       den_r [COEF_SETS];

  logic signed [SW-1:0]      x_r;
  logic signed [SW-1:0]      x1_r [COEF_SETS];
  logic signed [SW-1:0]      x2_r [COEF_SETS];
  logic signed [SW-1:0]      y1_r [COEF_SETS];
  logic signed [SW-1:0]      y2_r [COEF_SETS];
  logic                      sat_r;

  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      neg_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, term;
  logic signed [COEF_W-1:0]  coef_sel;
  logic signed [SW-1:0]      opnd_sel;
  logic signed [ACC_W-1:0]   rsum, shifted;
  logic signed [SW-1:0]      y_sat;
  logic                      clip;
  logic [1:0]                n_eff;

  logic                      out_valid_r;
  logic [SW-1:0]             out_sample_r;
  logic                      out_sat_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 2'd2;
      for (int i = 0; i < COEF_SETS; i++) begin
        num_r[i] <= '0;
        den_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_SECTIONS: active_r <= cfg_data[1:0];
        REG_SEC0_NUM:        num_r[0] <= cfg_data[3*COEF_W-1:0];
        REG_SEC0_DEN:        den_r[0] <= cfg_data[2*COEF_W-1:0];
        REG_SEC1_NUM:        num_r[1] <= cfg_data[3*COEF_W-1:0];
        REG_SEC1_DEN:        den_r[1] <= cfg_data[2*COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective section count: zero acts as one, clamp to the built maximum
  always_comb begin
    n_eff = (active_r == 2'd0) ? 2'd1 : active_r;
    if (n_eff > MAXN_V) n_eff = MAXN_V;
  end

  assign status.last_sec = ({1'b0, cmd.sec} + 2'd1) >= n_eff;
  assign status.out_free = !out_valid_r || out_tready;

  // Term selection for the shared multiplier
  always_comb begin
    case (cmd.step)
      STEP_B0: begin
        coef_sel = num_r[cmd.sec][COEF_W-1:0];
        opnd_sel = x_r;
      end
      STEP_B1: begin
        coef_sel = num_r[cmd.sec][2*COEF_W-1:COEF_W];
        opnd_sel = x1_r[cmd.sec];
      end
      STEP_B2: begin
        coef_sel = num_r[cmd.sec][3*COEF_W-1:2*COEF_W];
        opnd_sel = x2_r[cmd.sec];
      end
      STEP_A1: begin
        coef_sel = den_r[cmd.sec][COEF_W-1:0];
        opnd_sel = y1_r[cmd.sec];
      end
      STEP_A2: begin
        coef_sel = den_r[cmd.sec][2*COEF_W-1:COEF_W];
        opnd_sel = y2_r[cmd.sec];
      end
      default: begin
        coef_sel = '0;
        opnd_sel = '0;
      end
    endcase
  end

  assign prod_nxt = coef_sel * opnd_sel;
  assign term     = neg_r ? -ACC_W'(prod_r) : ACC_W'(prod_r);
  assign acc_nxt  = cmd.acc_first ? term : acc_r + term;

  // Round half up, floor shift, saturate
  assign rsum    = acc_r + HALF;
  assign shifted = rsum >>> COEF_FRAC_BITS;
  always_comb begin
    clip  = 1'b0;
    y_sat = shifted[SW-1:0];
    if (shifted > SMAX) begin
      clip  = 1'b1;
      y_sat = SMAX[SW-1:0];
    end else if (shifted < SMIN) begin
      clip  = 1'b1;
      y_sat = SMIN[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      neg_r  <= (cmd.step == STEP_A1) || (cmd.step == STEP_A2);
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Section state and running sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      sat_r <= 1'b0;
      for (int i = 0; i < COEF_SETS; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (cmd.start) begin
      x_r   <= sample_in;
      sat_r <= 1'b0;
    end else if (cmd.fin) begin
      x2_r[cmd.sec] <= x1_r[cmd.sec];
      x1_r[cmd.sec] <= x_r;
      y2_r[cmd.sec] <= y1_r[cmd.sec];
      y1_r[cmd.sec] <= y_sat;
      x_r           <= y_sat;
      sat_r         <= sat_r | clip;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= x_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign sample_out = out_sample_r;
  assign saturated  = out_sat_r;

endmodule

// ===== rtl/core/biquad_cascade_bandpass_filter.sv =====
// Top level of the cascaded direct-form-I biquad filter.
// One shared multiplier runs five products per section plus a drain and a round/saturate step;
//   a new sample is taken only after the previous result has entered the output register.
// Reset (rst_n low, synchronous): clears delay lines, coefficients to zero, two sections active,
//   output register empty.
module biquad_cascade_bandpass_filter
  import bqc_pkg::*;
#(
  parameter int SECTIONS       = 2,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data,
  // Input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,   // sample_in
  // Result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,  // sample_out
  output logic                                  out_tuser   // saturated
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  bqc_cmd_t                cmd;
  bqc_status_t             status;
  logic [SAMPLE_WIDTH-1:0] sample_out;

  // Controller: one item at a time, sections and MAC steps in sequence
  bqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: the result register lets the next sample in while a result waits
  bqc_dp #(
    .SECTIONS       (SECTIONS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (in_tdata[SAMPLE_WIDTH-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sample_out (sample_out),
    .saturated  (out_tuser)
  );

  // Zero-pad the sample up to whole bytes
  assign out_tdata = TDATA_W'(sample_out);

  // Hold off new input transactions once one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a sample is in flight");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // Round and update only after the accumulator drained
  a_fin_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> $past(cmd.acc_en) && !$past(cmd.mul_en))
    else $error("section finished before accumulation completed");

endmodule

// ===== tb/sv/tb_biquad_cascade_bandpass_filter.sv =====
// Self-checking stream testbench for the cascaded biquad filter, with a fixed-point predictor.
module tb_biquad_cascade_bandpass_filter
  import bqc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W       = 16;
  localparam int TDATA_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int COEF_FRAC_BITS = 14;
  localparam int MAX_SECTIONS   = 2;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int RANDOM_PHASES  = 8;
  // Slack on top of the longest section chain, so the datapath settles
  localparam int SETTLE_CYCLES  = 24;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int REPORT_LIMIT   = 10;

  // Flow-control profiles applied to the two stream sides
  typedef enum int {
    PACE_NONE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_t;

  // One filtered sample as it should appear on the result stream
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
  } filtered_t;

  // Predictor of the filter plus the queue of filtered samples still owed by the block
  class filter_tracker;
    logic [1:0]             sections_reg;
    logic [CFG_DATA_W-1:0]  num_reg [MAX_SECTIONS];
    logic [31:0]            den_reg [MAX_SECTIONS];
    logic signed [SAMPLE_W-1:0] x1 [MAX_SECTIONS];
    logic signed [SAMPLE_W-1:0] x2 [MAX_SECTIONS];
    logic signed [SAMPLE_W-1:0] y1 [MAX_SECTIONS];
    logic signed [SAMPLE_W-1:0] y2 [MAX_SECTIONS];
    filtered_t owed_samples [$];
    int failures;

    function new();
      sections_reg = 2'd2;
      for (int s = 0; s < MAX_SECTIONS; s++) begin
        num_reg[s] = '0;
        den_reg[s] = '0;
        x1[s] = '0;
        x2[s] = '0;
        y1[s] = '0;
        y2[s] = '0;
      end
      failures = 0;
    endfunction

    function int pending();
      return owed_samples.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ACTIVE_SECTIONS: sections_reg = value[1:0];
        REG_SEC0_NUM:        num_reg[0] = value;
        REG_SEC0_DEN:        den_reg[0] = value[31:0];
        REG_SEC1_NUM:        num_reg[1] = value;
        REG_SEC1_DEN:        den_reg[1] = value[31:0];
        default: ;
      endcase
    endfunction

    function longint coef_at(logic [CFG_DATA_W-1:0] packed_coefs, int slot);
      return longint'($signed(packed_coefs[slot*COEF_W +: COEF_W]));
    endfunction

    // Run one sample through the active sections and queue the result
    function void note_sample(logic [SAMPLE_W-1:0] raw);
      int count;
      int s;
      longint acc;
      longint rounded;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      filtered_t result;
      count = (sections_reg == 2'd0) ? 1 : int'(sections_reg);
      if (count > MAX_SECTIONS) count = MAX_SECTIONS;
      x = raw;
      result.clipped = 1'b0;
      for (s = 0; s < count; s++) begin
        acc = coef_at(num_reg[s], 0) * longint'(x)
            + coef_at(num_reg[s], 1) * longint'(x1[s])
            + coef_at(num_reg[s], 2) * longint'(x2[s])
            - coef_at(den_reg[s], 0) * longint'(y1[s])
            - coef_at(den_reg[s], 1) * longint'(y2[s]);
        // Round half up, then clip to the sample range
        rounded = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (rounded > 32767) begin
          rounded = 32767;
          result.clipped = 1'b1;
        end
        if (rounded < -32768) begin
          rounded = -32768;
          result.clipped = 1'b1;
        end
        y = rounded[SAMPLE_W-1:0];
        x2[s] = x1[s];
        x1[s] = x;
        y2[s] = y1[s];
        y1[s] = y;
        x = y;
      end
      result.sample = x;
      owed_samples.push_back(result);
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("ERROR: %s", what);
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] sample, logic clipped);
      filtered_t want;
      if (owed_samples.size() == 0) begin
        flag($sformatf("unexpected result sample_out=%0d saturated=%0b",
                       $signed(sample), clipped));
        return;
      end
      want = owed_samples.pop_front();
      if (want.sample !== sample)
        flag($sformatf("sample_out expected %0d got %0d",
                       $signed(want.sample), $signed(sample)));
      if (want.clipped !== clipped)
        flag($sformatf("saturated expected %0b got %0b (sample_out %0d)",
                       want.clipped, clipped, $signed(want.sample)));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata   = '0;   // sample_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;         // sample_out
  logic                  out_tuser;         // saturated

  filter_tracker tracker = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  biquad_cascade_bandpass_filter #(
    .SECTIONS       (MAX_SECTIONS),
    .SAMPLE_WIDTH   (SAMPLE_W),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("biquad_cascade_bandpass_filter: mismatch");
      $finish;
    end
  end

  // Result side: check every accepted transaction against the oldest owed sample,
  // then pick the ready level for the next edge according to the stall profile.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_output(out_tdata[SAMPLE_W-1:0], out_tuser);
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  task automatic set_pacing(input pace_t mode);
    case (mode)
      PACE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER: begin
        send_idle_pct  = 48;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 48;
      end
      default: begin
        send_idle_pct  = 7;
        recv_stall_pct = 7;
      end
    endcase
  endtask

  // Offer one sample and hold it until the block takes it. Leave tvalid high on
  // return so back-to-back transactions never toggle it within one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(sample);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_sample(sample);
  endtask

  // Drop tvalid, wait for every owed result, then let the datapath settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.note_config(idx, value);
  endtask

  // Write all five registers plus one write to an unused index, which must be ignored.
  // Unused upper data bits carry random junk.
  task automatic program_filter(input logic [1:0] act,
                                input logic [CFG_DATA_W-1:0] n0, input logic [31:0] d0,
                                input logic [CFG_DATA_W-1:0] n1, input logic [31:0] d1);
    logic [CFG_DATA_W-1:0] filler;
    filler = {16'($urandom), $urandom};
    cfg_write(REG_ACTIVE_SECTIONS, {filler[CFG_DATA_W-1:2], act});
    cfg_write(REG_SEC1_DEN + CFG_IDX_W'(1 + $urandom_range(2, 0)),
              {16'($urandom), $urandom});
    cfg_write(REG_SEC0_NUM, n0);
    cfg_write(REG_SEC0_DEN, {filler[CFG_DATA_W-1:32], d0});
    cfg_write(REG_SEC1_NUM, n1);
    cfg_write(REG_SEC1_DEN, {filler[CFG_DATA_W-1:32], d1});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] extreme_coef();
    return $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
  endfunction

  // Stable resonator: |a1| < 1 + a2, a2 < 1, numerator roughly b0*(1 - z^-2)
  task automatic pick_bandpass(output logic [CFG_DATA_W-1:0] num, output logic [31:0] den);
    int a1;
    int a2;
    int b0;
    int b1;
    a2 = $urandom_range(15800, 6000);
    a1 = $urandom_range(16383 + a2, 0);
    if ($urandom_range(1, 0)) a1 = -a1;
    b0 = $urandom_range(6000, 0);
    b1 = ($urandom_range(3, 0) == 0) ? int'($urandom_range(4000, 0)) - 2000 : 0;
    num = {16'(-b0), 16'(b1), 16'(b0)};
    den = {16'(a2), 16'(a1)};
  endtask

  // Mostly full-scale noise, with some small signals and rail values mixed in
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9, 0))
      0:       return extreme_coef();
      1, 2:    return SAMPLE_W'(int'($urandom_range(1023, 0)) - 512);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    int k;
    logic [1:0]            act;
    logic [CFG_DATA_W-1:0] n0;
    logic [CFG_DATA_W-1:0] n1;
    logic [31:0]           d0;
    logic [31:0]           d1;

    set_pacing(PACE_NONE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: zero coefficients, two sections, so everything comes out zero
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    wait_drained();

    // Single pass-through section (b0 = 1.0); second section set to rails but idle
    program_filter(2'd1, 48'h0000_0000_4000, 32'h0, {3{16'h8000}}, 32'h8000_8000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5A5A);
    wait_drained();

    // Half gain: odd inputs land on rounding ties, which go toward plus infinity
    program_filter(2'd1, 48'h0000_0000_2000, 32'h0, 48'h0, 32'h0);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    send_sample(16'hFFFD);
    wait_drained();

    // Gain +2 then -2: clip in both sections, both directions
    program_filter(2'd2, 48'h0000_0000_7FFF, 32'h0, 48'h0000_0000_8000, 32'h0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'd100);
    wait_drained();

    // Count three acts as two; every coefficient at a rail so feedback saturates hard
    program_filter(2'd3, 48'h8000_7FFF_7FFF, 32'h8000_7FFF,
                   48'h7FFF_8000_8000, 32'h7FFF_8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    wait_drained();

    // Random phases: reprogram while idle, rotate the flow-control profiles
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_bandpass(n0, d0);
      pick_bandpass(n1, d1);
      case (phase)
        0, 6: act = 2'd2;
        1: begin
          act = 2'd1;
          n1  = {16'($urandom), $urandom};
          d1  = $urandom;
        end
        2: begin
          act = 2'd2;
          n1  = {16'($urandom), $urandom};
          d1  = $urandom;
        end
        3: act = 2'd3;
        4: begin
          act = 2'd0;
          n0  = {16'($urandom), $urandom};
          d0  = $urandom;
          n1  = {16'($urandom), $urandom};
          d1  = $urandom;
        end
        5: begin
          act = 2'd2;
          n0  = {extreme_coef(), extreme_coef(), extreme_coef()};
          d0  = {extreme_coef(), extreme_coef()};
          n1  = {extreme_coef(), extreme_coef(), extreme_coef()};
          d1  = {extreme_coef(), extreme_coef()};
        end
        default: begin
          act = 2'd1;
          n0  = {16'($urandom), $urandom};
          d0  = $urandom;
        end
      endcase
      program_filter(act, n0, d0, n1, d1);
      set_pacing(pace_t'(phase % 4));
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Once, hold the sender until the block has delivered everything
        if (phase == 1 && k == ITEMS_PER_PHASE / 2) wait_drained();
        send_sample(random_sample());
      end
      wait_drained();
    end

    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("biquad_cascade_bandpass_filter: match");
    end else begin
      $display("biquad_cascade_bandpass_filter: mismatch");
    end
    $finish;
  end

endmodule
